// ===== design/bia_pkg.sv =====
package bia_pkg;

    localparam int ID_W  = 4;
    localparam int CTX_W = 8;
    localparam int EVT_W = 3;

    typedef enum logic [1:0] {
        MODE_ASSIGN  = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_SET     = 2'd2,
        MODE_GET     = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [ID_W-1:0]    bearer_id;
        logic [CTX_W-1:0]   context_id;
        logic               is_default;
        logic               new_status;
        logic               terminal_req;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    assigned_id;
        logic               status_out;
        logic               notify;
        logic [CTX_W-1:0]   notify_context;
        logic [EVT_W-1:0]   pdn_event;
    } rsp_t;

endpackage

// ===== design/bearer_id_allocation_table_unit.sv =====
// Channel   Handshake        Fields
// command   start, busy      mode, bearer_id, context_id, is_default,
//                            new_status, terminal_req
// result    done (strobe)    ok, assigned_id, status_out, notify,
//                            notify_context, pdn_event
//
// An item is taken when start is high and busy is low; busy stays low, so one
// item per cycle is accepted. The item is first held in the command register;
// the table update and the result register then load together, and done
// strobes with that result. Reset clears the table flags and the search
// pointer at once.
// The receiver cannot stall: done is high for a single cycle per result, and the result fields hold until the next one.
module bearer_id_allocation_table_unit #(
    parameter int ID_MIN  = 5,
    parameter int ID_MAX  = 15,
    parameter int ENTRIES = 11
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [3:0] bearer_id,
    input  logic [7:0] context_id,
    input  logic       is_default,
    input  logic       new_status,
    input  logic       terminal_req,
    output logic       done,
    output logic       ok,
    output logic [3:0] assigned_id,
    output logic       status_out,
    output logic       notify,
    output logic [7:0] notify_context,
    output logic [2:0] pdn_event
);

    import bia_pkg::*;

    cmd_t cmd_reg;
    logic cmd_vld_reg;
    rsp_t rsp_reg;
    logic done_reg;
    rsp_t rsp_comb;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cmd_vld_reg <= start && !busy;
            done_reg    <= cmd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg.mode         <= mode_t'(mode);
            cmd_reg.bearer_id    <= bearer_id;
            cmd_reg.context_id   <= context_id;
            cmd_reg.is_default   <= is_default;
            cmd_reg.new_status   <= new_status;
            cmd_reg.terminal_req <= terminal_req;
        end
        if (cmd_vld_reg)
        begin
            rsp_reg <= rsp_comb;
        end
    end

    bia_table #(
        .ID_MIN  (ID_MIN),
        .ID_MAX  (ID_MAX),
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_vld (cmd_vld_reg),
        .cmd     (cmd_reg),
        .rsp     (rsp_comb)
    );

    assign done           = done_reg;
    assign ok             = rsp_reg.ok;
    assign assigned_id    = rsp_reg.assigned_id;
    assign status_out     = rsp_reg.status_out;
    assign notify         = rsp_reg.notify;
    assign notify_context = rsp_reg.notify_context;
    assign pdn_event      = rsp_reg.pdn_event;

endmodule

// ===== design/bia_find.sv =====
module bia_find #(
    parameter int ENTRIES = 11,
    parameter int IDX_W   = 4
) (
    input  logic [ENTRIES-1:0] free_mask,
    input  logic [IDX_W-1:0]   start,
    output logic               found,
    output logic [IDX_W-1:0]   slot
);

    logic [ENTRIES-1:0] upper_mask;
    logic [IDX_W-1:0]   upper_slot;
    logic [IDX_W-1:0]   any_slot;

    always_comb
    begin
        upper_mask = '0;
        upper_slot = '0;
        any_slot   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            upper_mask[i] = free_mask[i] && (IDX_W'(i) >= start);
            if (upper_mask[i])
            begin
                upper_slot = IDX_W'(i);
            end
            if (free_mask[i])
            begin
                any_slot = IDX_W'(i);
            end
        end
    end

    // prefer the first free slot at or after the pointer, else wrap
    assign found = |free_mask;
    assign slot  = (|upper_mask) ? upper_slot : any_slot;

endmodule

// ===== design/bia_table.sv =====
module bia_table #(
    parameter int ID_MIN  = 5,
    parameter int ID_MAX  = 15,
    parameter int ENTRIES = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_vld,
    input  bia_pkg::cmd_t cmd,
    output bia_pkg::rsp_t rsp
);

    import bia_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SPAN   = (ID_MAX >= ID_MIN) ? (ID_MAX - ID_MIN + 1) : 0;
    localparam int USABLE = (SPAN < ENTRIES) ? SPAN : ENTRIES;

    localparam logic [ID_W-1:0] ID_MIN_L = ID_W'(ID_MIN);
    localparam logic [ID_W-1:0] ID_MAX_L = ID_W'(ID_MAX);
    localparam logic [ID_W-1:0] USABLE_L = ID_W'(USABLE);

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] active_reg, active_next;
    logic [ENTRIES-1:0] default_reg, default_next;
    logic [ID_W-1:0]    next_index_reg, next_index_next;
    logic [CTX_W-1:0]   ctx_reg [ENTRIES];

    logic [ID_W-1:0]    id_off;
    logic               in_range;
    logic [IDX_W-1:0]   id_slot;
    logic               id_valid;
    logic               id_active;
    logic               id_default;

    logic [ENTRIES-1:0] free_mask;
    logic [IDX_W-1:0]   start;
    logic               find_found;
    logic [IDX_W-1:0]   find_slot;

    logic [IDX_W-1:0]   op_slot;
    logic               ctx_we;

    assign id_off     = cmd.bearer_id - ID_MIN_L;
    assign in_range   = (cmd.bearer_id >= ID_MIN_L) && (cmd.bearer_id <= ID_MAX_L)
                        && (id_off < USABLE_L);
    assign id_slot    = id_off[IDX_W-1:0];
    assign id_valid   = in_range && valid_reg[id_slot];
    assign id_active  = in_range && active_reg[id_slot];
    assign id_default = in_range && default_reg[id_slot];

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            free_mask[i] = !valid_reg[i] && (i < USABLE);
        end
    end

    assign start = (next_index_reg < USABLE_L) ? next_index_reg[IDX_W-1:0] : '0;

    bia_find #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_find (
        .free_mask (free_mask),
        .start     (start),
        .found     (find_found),
        .slot      (find_slot)
    );

    always_comb
    begin
        valid_next      = valid_reg;
        active_next     = active_reg;
        default_next    = default_reg;
        next_index_next = next_index_reg;
        op_slot         = id_slot;
        ctx_we          = 1'b0;
        rsp             = '0;
        unique case (cmd.mode)
            MODE_ASSIGN:
            begin
                if (cmd.bearer_id != '0)
                begin
                    rsp.ok = in_range && !id_valid;
                end
                else
                begin
                    op_slot = find_slot;
                    rsp.ok  = find_found;
                end
                if (rsp.ok)
                begin
                    valid_next[op_slot]   = 1'b1;
                    active_next[op_slot]  = 1'b0;
                    default_next[op_slot] = cmd.is_default;
                    next_index_next       = ID_W'(op_slot) + ID_W'(1);
                    rsp.assigned_id       = ID_W'(op_slot) + ID_MIN_L;
                    ctx_we                = cmd_vld;
                end
            end
            MODE_RELEASE:
            begin
                rsp.ok = id_valid && !id_active;
                if (rsp.ok)
                begin
                    valid_next[op_slot]   = 1'b0;
                    active_next[op_slot]  = 1'b0;
                    default_next[op_slot] = 1'b0;
                end
            end
            MODE_SET:
            begin
                rsp.ok = id_valid && (id_active != cmd.new_status);
                if (rsp.ok)
                begin
                    active_next[op_slot] = cmd.new_status;
                    rsp.notify           = 1'b1;
                    rsp.notify_context   = ctx_reg[op_slot];
                    rsp.pdn_event        = {cmd.terminal_req, id_default, cmd.new_status};
                end
            end
            MODE_GET:
            begin
                rsp.ok         = 1'b1;
                rsp.status_out = id_valid && id_active;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            active_reg     <= '0;
            default_reg    <= '0;
            next_index_reg <= '0;
        end
        else if (cmd_vld)
        begin
            valid_reg      <= valid_next;
            active_reg     <= active_next;
            default_reg    <= default_next;
            next_index_reg <= next_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctx_we)
        begin
            ctx_reg[op_slot] <= cmd.context_id;
        end
    end

endmodule
